// ===== src/circular_monotone_subsequence_assert.svh =====
// assertion macros for the circular monotone subsequence block
// expects signals named clock and reset in the scope of each use
`ifndef CIRCULAR_MONOTONE_SUBSEQUENCE_ASSERT_SVH
`define CIRCULAR_MONOTONE_SUBSEQUENCE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CMS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cms: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define CMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cms: next-cycle check failed");

`endif

// ===== src/cms_pkg.sv =====
// shared types and constants of the circular monotone subsequence block
// used by cms_ctrl, cms_datapath and the top level; no dependencies
package cms_pkg;

   localparam int ELEM_W = 32;
   localparam int RUN_W  = 7;

   // address source for the table reads
   typedef enum logic [1:0] {
      ADDR_I,
      ADDR_J,
      ADDR_P
   } addr_src_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         store;
      logic         cnt_clr;
      logic         i_init;
      logic         i_dec;
      logic         rd_en;
      addr_src_type rd_src;
      logic         row_init;
      logic         j_eval;
      logic         row_wr;
      logic         best_init;
      logic         best_eval;
      logic         walk_init;
      logic         walk_step;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic close;
      logic row_end;
      logic j_last;
      logic brk;
      logic i_zero;
      logic p_last;
      logic last_out;
   } sts_type;

endpackage

// ===== src/cms_datapath.sv =====
// datapath: value store, chain tables, scan registers and result registers
// depends on cms_pkg and the assertion macro header
`include "circular_monotone_subsequence_assert.svh"

module cms_datapath
   import cms_pkg::*;
#(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic signed [ELEM_W-1:0] req_value,
   input  logic                     req_last_item,
   input  logic                     csr_valid,
   input  logic                     csr_data,
   output logic signed [ELEM_W-1:0] rsp_element,
   output logic [RUN_W-1:0]         rsp_run_length,
   output logic                     rsp_final_element
);

   localparam int VAL_AW = $clog2(MAX_ELEMENTS);
   localparam int POS_W  = $clog2(2 * MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int TOT_W  = POS_W + 1;
   localparam int TAB_D  = 2 * MAX_ELEMENTS;

   // memories
   logic signed [ELEM_W-1:0] val_mem  [MAX_ELEMENTS];
   logic [RUN_W-1:0]         len_mem  [TAB_D];
   logic [POS_W-1:0]         succ_mem [TAB_D];
   logic [POS_W-1:0]         tail_mem [TAB_D];

   // control registers
   logic [CNT_W-1:0] cnt_ff;
   logic             dir_ff;

   // payload registers
   logic signed [ELEM_W-1:0] val_rd_ff;
   logic [RUN_W-1:0]         len_rd_ff;
   logic [POS_W-1:0]         succ_rd_ff;
   logic [POS_W-1:0]         tail_rd_ff;
   logic signed [ELEM_W-1:0] vi_ff;
   logic [POS_W-1:0]         i_ff;
   logic [POS_W-1:0]         j_ff;
   logic [POS_W-1:0]         p_ff;
   logic [RUN_W-1:0]         cur_len_ff;
   logic [POS_W-1:0]         cur_succ_ff;
   logic [POS_W-1:0]         cur_tail_ff;
   logic [POS_W-1:0]         best_ff;
   logic [RUN_W-1:0]         best_len_ff;
   logic [RUN_W-1:0]         rem_ff;

   logic [TOT_W-1:0]  n_ext;
   logic [TOT_W-1:0]  nm1;
   logic [TOT_W-1:0]  total;
   logic [POS_W-1:0]  rd_addr;
   logic [TOT_W-1:0]  rd_ext;
   logic [TOT_W-1:0]  wrap_k;
   logic [VAL_AW-1:0] val_addr;
   logic              better;
   logic              upd;

   // array size and doubled length
   assign n_ext = TOT_W'(cnt_ff);
   assign nm1   = n_ext - TOT_W'(1);
   assign total = n_ext << 1;

   // read address select
   always_comb begin
      unique case (cmd.rd_src)
         ADDR_I:  rd_addr = i_ff;
         ADDR_J:  rd_addr = j_ff;
         ADDR_P:  rd_addr = p_ff;
         default: rd_addr = p_ff;
      endcase
   end

   // doubled position folded back onto the stored array
   assign rd_ext   = TOT_W'(rd_addr);
   assign wrap_k   = (rd_ext < n_ext) ? rd_ext : (rd_ext - n_ext);
   assign val_addr = wrap_k[VAL_AW-1:0];

   // candidate test for the scan step
   assign better = dir_ff ? (val_rd_ff < vi_ff) : (val_rd_ff > vi_ff);
   assign upd    = !sts.brk && better && ((len_rd_ff + RUN_W'(1)) > cur_len_ff);

   // status
   assign sts.close    = req_last_item || (cnt_ff == CNT_W'(MAX_ELEMENTS - 1));
   assign sts.row_end  = (TOT_W'(i_ff) + TOT_W'(1)) >= total;
   assign sts.j_last   = (TOT_W'(j_ff) + TOT_W'(1)) >= total;
   assign sts.brk      = (TOT_W'(tail_rd_ff) - TOT_W'(i_ff)) >= nm1;
   assign sts.i_zero   = (i_ff == '0);
   assign sts.p_last   = (TOT_W'(p_ff) + TOT_W'(1)) >= total;
   assign sts.last_out = (rem_ff == RUN_W'(1));

   // result fields
   assign rsp_element       = val_rd_ff;
   assign rsp_run_length    = best_len_ff;
   assign rsp_final_element = sts.last_out;

   // element count and direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         dir_ff <= 1'b0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.store) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (csr_valid) begin
            dir_ff <= csr_data;
         end
      end
   end

   // value store
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         val_mem[cnt_ff[VAL_AW-1:0]] <= req_value;
      end
      if (cmd.rd_en) begin
         val_rd_ff <= val_mem[val_addr];
      end
   end

   // chain tables, written once per position
   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         len_mem[i_ff]  <= cur_len_ff;
         succ_mem[i_ff] <= cur_succ_ff;
         tail_mem[i_ff] <= cur_tail_ff;
      end
      if (cmd.rd_en) begin
         len_rd_ff  <= len_mem[rd_addr];
         succ_rd_ff <= succ_mem[rd_addr];
         tail_rd_ff <= tail_mem[rd_addr];
      end
   end

   // position counter and running best of the current row
   always_ff @(posedge clock) begin
      if (cmd.i_init) begin
         i_ff <= POS_W'(total - TOT_W'(1));
      end else if (cmd.i_dec) begin
         i_ff <= i_ff - POS_W'(1);
      end
      if (cmd.row_init) begin
         vi_ff       <= val_rd_ff;
         cur_len_ff  <= RUN_W'(1);
         cur_succ_ff <= i_ff;
         cur_tail_ff <= i_ff;
         j_ff        <= POS_W'(TOT_W'(i_ff) + TOT_W'(1));
      end else if (cmd.j_eval) begin
         if (upd) begin
            cur_len_ff  <= len_rd_ff + RUN_W'(1);
            cur_succ_ff <= j_ff;
            cur_tail_ff <= tail_rd_ff;
         end
         j_ff <= POS_W'(TOT_W'(j_ff) + TOT_W'(1));
      end
   end

   // best search and chain walk
   always_ff @(posedge clock) begin
      if (cmd.best_init) begin
         p_ff        <= '0;
         best_ff     <= '0;
         best_len_ff <= '0;
      end else if (cmd.best_eval) begin
         if (len_rd_ff > best_len_ff) begin
            best_ff     <= p_ff;
            best_len_ff <= len_rd_ff;
         end
         p_ff <= POS_W'(TOT_W'(p_ff) + TOT_W'(1));
      end else if (cmd.walk_init) begin
         p_ff   <= best_ff;
         rem_ff <= best_len_ff;
      end else if (cmd.walk_step) begin
         p_ff   <= succ_rd_ff;
         rem_ff <= rem_ff - RUN_W'(1);
      end
   end

   // checks
   `CMS_ASSERT_SAME(a_scan_after_row, cmd.rd_en && (cmd.rd_src == ADDR_J), j_ff > i_ff)
   `CMS_ASSERT_SAME(a_walk_not_empty, cmd.walk_step, rem_ff != '0)
   `CMS_ASSERT_NEXT(a_best_found, cmd.best_eval, best_len_ff != '0)

endmodule

// ===== src/cms_ctrl.sv =====
// controller: sequences loading, the chain program, best search and output
// depends on cms_pkg and the assertion macro header
`include "circular_monotone_subsequence_assert.svh"

module cms_ctrl
   import cms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DP_INIT,
      ST_ROW_RD,
      ST_ROW_INIT,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_ROW_WR,
      ST_BEST_RD,
      ST_BEST_EVAL,
      ST_WALK_INIT,
      ST_WALK_RD,
      ST_WALK_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = ADDR_P;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (sts.close) begin
                  state_in = ST_DP_INIT;
               end
            end
         end
         ST_DP_INIT: begin
            cmd.i_init = 1'b1;
            state_in   = ST_ROW_RD;
         end
         ST_ROW_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = ADDR_I;
            state_in   = ST_ROW_INIT;
         end
         ST_ROW_INIT: begin
            cmd.row_init = 1'b1;
            state_in     = sts.row_end ? ST_ROW_WR : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = ADDR_J;
            state_in   = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            cmd.j_eval = 1'b1;
            state_in   = (sts.brk || sts.j_last) ? ST_ROW_WR : ST_SCAN_RD;
         end
         ST_ROW_WR: begin
            cmd.row_wr = 1'b1;
            if (sts.i_zero) begin
               cmd.best_init = 1'b1;
               state_in      = ST_BEST_RD;
            end else begin
               cmd.i_dec = 1'b1;
               state_in  = ST_ROW_RD;
            end
         end
         ST_BEST_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = ADDR_P;
            state_in   = ST_BEST_EVAL;
         end
         ST_BEST_EVAL: begin
            cmd.best_eval = 1'b1;
            state_in      = sts.p_last ? ST_WALK_INIT : ST_BEST_RD;
         end
         ST_WALK_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = ADDR_P;
            state_in   = ST_WALK_OUT;
         end
         ST_WALK_OUT: begin
            if (!rsp_stall) begin
               cmd.walk_step = 1'b1;
               if (sts.last_out) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_LOAD);
         rsp_valid_ff <= (state_in == ST_WALK_OUT);
      end
   end

   // checks
   `CMS_ASSERT_SAME(a_out_blocks_in, rsp_valid_ff, req_stall_ff)
   `CMS_ASSERT_NEXT(a_close_stalls, !req_stall_ff && req_valid && sts.close, req_stall_ff)
   `CMS_ASSERT_NEXT(a_reopen, rsp_valid_ff && !rsp_stall && sts.last_out, !req_stall_ff)

endmodule

// ===== src/circular_monotone_subsequence.sv =====
// top level of the circular monotone subsequence block
// depends on cms_pkg, cms_ctrl and cms_datapath
//
//  channel  ports                                      direction
//  req      req_valid req_stall req_value req_last_item  in
//  rsp      rsp_valid rsp_stall rsp_element            out
//           rsp_run_length rsp_final_element
//  csr      csr_valid csr_ready csr_data               in
//
// loading takes one cycle per request; the request that closes the array
// starts the chain program, which runs 2n rows of read, init, scan and write,
// the scan reading and evaluating at most n-1 positions up to the wrap stop;
// the best search reads all 2n positions; each result then waits out stalls
// requests are stalled from the closing request until the last result goes
// reset is synchronous; it clears the count, direction and control state

module circular_monotone_subsequence
   import cms_pkg::*;
#(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_value,
   input  logic                     req_last_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_element,
   output logic [RUN_W-1:0]         rsp_run_length,
   output logic                     rsp_final_element,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   cmd_type cmd;
   sts_type sts;

   // direction register is always writable
   assign csr_ready = 1'b1;

   // sequencer
   cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and arithmetic
   cms_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_value         (req_value),
      .req_last_item     (req_last_item),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_element       (rsp_element),
      .rsp_run_length    (rsp_run_length),
      .rsp_final_element (rsp_final_element)
   );

endmodule
